// ----- rtl/core/bpa_pkg.sv -----
// Package with button masks, report constants and priority helpers for the autorepeat block.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int TimerWidth = 24;
  localparam int ButtonWidth = 16;
  localparam int CodeWidth = 3;

  localparam logic [7:0] ID_ACCEPTED = 8'hA1;
  localparam logic [10:0] MIN_LENGTH = 11'd4;

  localparam logic [ButtonWidth-1:0] BIT_A = 16'h0008;
  localparam logic [ButtonWidth-1:0] BIT_HOME = 16'h0080;
  localparam logic [ButtonWidth-1:0] BIT_LEFT = 16'h0100;
  localparam logic [ButtonWidth-1:0] BIT_RIGHT = 16'h0200;
  localparam logic [ButtonWidth-1:0] BIT_DOWN = 16'h0400;
  localparam logic [ButtonWidth-1:0] BIT_UP = 16'h0800;
  localparam logic [ButtonWidth-1:0] DIR_BITS = BIT_UP | BIT_DOWN | BIT_LEFT | BIT_RIGHT;

  localparam logic [TimerWidth-1:0] TIMER_MAX = 24'hFFFFFF;
  localparam logic [TimerWidth-1:0] DELAY_RESET = 24'd400000;
  localparam logic [TimerWidth-1:0] PERIOD_RESET = 24'd100000;

  localparam logic [0:0] REG_DELAY = 1'b0;
  localparam logic [0:0] REG_PERIOD = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Repeat codes: zero means no repeat button, otherwise action plus one.
  typedef enum logic [CodeWidth-1:0] {
    CODE_NONE = 3'd0,
    CODE_UP = 3'd1,
    CODE_DOWN = 3'd2,
    CODE_LEFT = 3'd3,
    CODE_RIGHT = 3'd4,
    CODE_SELECT = 3'd5,
    CODE_SHOT = 3'd6
  } code_t;

  typedef struct packed {
    logic [CodeWidth-1:0] action;
    logic is_repeat;
  } result_t;

  function automatic logic [CodeWidth-1:0] pick_first(input logic [ButtonWidth-1:0] word);
    logic [CodeWidth-1:0] code;
    code = CODE_NONE;
    if ((word & BIT_UP) != '0) code = CODE_UP;
    else if ((word & BIT_DOWN) != '0) code = CODE_DOWN;
    else if ((word & BIT_LEFT) != '0) code = CODE_LEFT;
    else if ((word & BIT_RIGHT) != '0) code = CODE_RIGHT;
    else if ((word & BIT_A) != '0) code = CODE_SELECT;
    else if ((word & BIT_HOME) != '0) code = CODE_SHOT;
    return code;
  endfunction

  function automatic logic [ButtonWidth-1:0] code_mask(input logic [CodeWidth-1:0] code);
    logic [ButtonWidth-1:0] mask;
    unique case (code)
      CODE_UP: mask = BIT_UP;
      CODE_DOWN: mask = BIT_DOWN;
      CODE_LEFT: mask = BIT_LEFT;
      CODE_RIGHT: mask = BIT_RIGHT;
      CODE_SELECT: mask = BIT_A;
      CODE_SHOT: mask = BIT_HOME;
      default: mask = '0;
    endcase
    return mask;
  endfunction

endpackage

// ----- rtl/core/button_press_autorepeat.sv -----
// Top level of the button press and autorepeat block for one controller.
`timescale 1ns / 1ps
// Usage: the input channel (in_valid, in_ready) carries one transaction per input report
// or per time tick, selected by kind. A report with id 0xA1 and a length of at least four
// bytes updates the held buttons; a tick advances the saturating repeat timers.
// The output channel (out_valid, out_ready) carries at most one action per input
// transaction: a press of the highest-priority new button or an autorepeat action.
// A result is registered in the output queue before it is visible on the output channel.
// Throughput is one transaction per cycle while in_ready is high, set by the single pass
// through the edge, priority and timer compare logic ahead of the state and result registers.
// Results go into a two-entry output queue, so input is still taken while one result waits;
// in_ready drops whenever both entries are full, even if the receiver is ready.
// The APB port holds repeat_delay at address 0 and repeat_period at address 4.
// Synchronous reset clears held buttons, the repeat button, both timers and the queue,
// and loads the delay and period with their default values.
module button_press_autorepeat
  import bpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [7:0]            report_id,
  input  logic [10:0]           report_length,
  input  logic [ButtonWidth-1:0] buttons,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CodeWidth-1:0]  action,
  output logic                  is_repeat
);

  logic [TimerWidth-1:0] repeat_delay;
  logic [TimerWidth-1:0] repeat_period;
  logic [ButtonWidth-1:0] held_buttons;
  logic [CodeWidth-1:0] repeat_code;
  logic [TimerWidth-1:0] since_start;
  logic [TimerWidth-1:0] since_last;

  logic [ButtonWidth-1:0] held_buttons_next;
  logic [CodeWidth-1:0] repeat_code_next;
  logic [TimerWidth-1:0] since_start_next;
  logic [TimerWidth-1:0] since_last_next;

  result_t q0;
  result_t q1;
  logic [1:0] count;

  logic accept;
  logic pop;
  logic emit;
  result_t res;
  logic [TimerWidth-1:0] start_inc;
  logic [TimerWidth-1:0] last_inc;
  logic [ButtonWidth-1:0] rep_mask;
  logic [CodeWidth-1:0] first;
  logic report_ok;
  logic due_tick;
  logic due_report;
  logic cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_PERIOD) ? {8'd0, repeat_period} : {8'd0, repeat_delay};

  assign in_ready = (count != 2'd2);
  assign accept = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign pop = out_valid && out_ready;
  assign action = q0.action;
  assign is_repeat = q0.is_repeat;

  assign start_inc = (since_start == TIMER_MAX) ? since_start : since_start + 1'b1;
  assign last_inc = (since_last == TIMER_MAX) ? since_last : since_last + 1'b1;
  assign rep_mask = code_mask(repeat_code);
  assign first = pick_first(buttons & ~held_buttons);
  assign report_ok = (report_length >= MIN_LENGTH) && (report_id == ID_ACCEPTED);
  assign due_tick = (start_inc >= repeat_delay) && (last_inc >= repeat_period);
  assign due_report = (since_start >= repeat_delay) && (since_last >= repeat_period);

  always_comb begin
    held_buttons_next = held_buttons;
    repeat_code_next = repeat_code;
    since_start_next = since_start;
    since_last_next = since_last;
    emit = 1'b0;
    res.action = repeat_code - 1'b1;
    res.is_repeat = 1'b1;
    if (kind == KIND_TICK) begin
      since_start_next = start_inc;
      since_last_next = last_inc;
      if ((held_buttons & rep_mask) != '0 && due_tick) begin
        since_last_next = '0;
        emit = 1'b1;
      end
    end else if (report_ok) begin
      held_buttons_next = buttons;
      if (first != CODE_NONE) begin
        emit = 1'b1;
        res.action = first - 1'b1;
        res.is_repeat = 1'b0;
        repeat_code_next = first;
        since_start_next = '0;
        since_last_next = '0;
      end else if ((buttons & rep_mask) == '0) begin
        repeat_code_next = pick_first(buttons & DIR_BITS);
        since_start_next = '0;
        since_last_next = '0;
      end else if (due_report) begin
        since_last_next = '0;
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay <= DELAY_RESET;
      repeat_period <= PERIOD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_PERIOD) begin
        repeat_period <= pwdata[TimerWidth-1:0];
      end else begin
        repeat_delay <= pwdata[TimerWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_buttons <= '0;
      repeat_code <= CODE_NONE;
      since_start <= '0;
      since_last <= '0;
    end else if (accept) begin
      held_buttons <= held_buttons_next;
      repeat_code <= repeat_code_next;
      since_start <= since_start_next;
      since_last <= since_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (accept && emit && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !(accept && emit)) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (accept && emit && count == 2'd1) begin
        q0 <= res;
      end else begin
        q0 <= q1;
      end
      if (accept && emit && count == 2'd2) begin
        q1 <= res;
      end
    end else if (accept && emit) begin
      if (count == 2'd0) begin
        q0 <= res;
      end else begin
        q1 <= res;
      end
    end
  end

endmodule
